[design/smi_pkg.sv]
// Package with the shared types and codes of the sign-magnitude integer ALU.
`timescale 1ns / 1ps
`default_nettype none
package smi_pkg;

	localparam int MAG_W = 125;

	typedef enum logic [3:0] {
		OP_ADD  = 4'd0,
		OP_SUB  = 4'd1,
		OP_MUL  = 4'd2,
		OP_DIV  = 4'd3,
		OP_MOD  = 4'd4,
		OP_AND  = 4'd5,
		OP_OR   = 4'd6,
		OP_XOR  = 4'd7,
		OP_SHL  = 4'd8,
		OP_SHR  = 4'd9,
		OP_CMP  = 4'd10,
		OP_GCD  = 4'd11,
		OP_NONE = 4'd15
	} op_t;

	localparam logic [1:0] CMP_LT = 2'b11;
	localparam logic [1:0] CMP_EQ = 2'b00;
	localparam logic [1:0] CMP_GT = 2'b01;

	typedef struct packed {
		logic             neg;
		logic             ovf;
		logic             nan;
		logic [MAG_W-1:0] mag;
	} num_t;

	typedef struct packed {
		op_t        op;
		num_t       a;
		num_t       b;
		logic [7:0] shift;
		logic       a_zero;
		logic       b_zero;
	} item_t;

	typedef struct packed {
		logic             neg;
		logic             ovf;
		logic             nan;
		logic [MAG_W-1:0] mag;
		logic [1:0]       cmp;
	} res_t;

endpackage
`default_nettype wire

[design/smi_front.sv]
// Front end: accepts requests, decodes and classifies them, and queues them.
`timescale 1ns / 1ps
`default_nettype none
module smi_front #(
	parameter int MAG_BITS = 125
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_ready,
	input  wire [3:0]           action,
	input  wire smi_pkg::num_t  a_raw,
	input  wire smi_pkg::num_t  b_raw,
	input  wire [7:0]           shift_count,
	output logic                q_valid,
	input  wire                 q_ready,
	output smi_pkg::item_t      q_item
);

	localparam logic [smi_pkg::MAG_W-1:0] MASK =
		{smi_pkg::MAG_W{1'b1}} >> (smi_pkg::MAG_W - MAG_BITS);

	smi_pkg::item_t ent_q [2];
	logic           wr_q, rd_q;
	logic [1:0]     cnt_q;
	smi_pkg::item_t cls;
	logic           push, pop;

	always_comb begin
		cls = '0;
		cls.op = (action <= 4'(smi_pkg::OP_GCD)) ? smi_pkg::op_t'(action) : smi_pkg::OP_NONE;
		cls.a = a_raw;
		cls.b = b_raw;
		cls.a.mag = a_raw.mag & MASK;
		cls.b.mag = b_raw.mag & MASK;
		cls.shift = shift_count;
		cls.a_zero = !a_raw.ovf && !a_raw.nan && ((a_raw.mag & MASK) == '0);
		cls.b_zero = !b_raw.ovf && !b_raw.nan && ((b_raw.mag & MASK) == '0);
	end

	assign in_ready = (cnt_q != 2'd2);
	assign q_valid  = (cnt_q != 2'd0);
	assign q_item   = ent_q[rd_q];
	assign push     = in_valid && in_ready;
	assign pop      = q_valid && q_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

endmodule
`default_nettype wire

[design/smi_back.sv]
// Back end: executes queued operations, the long ones in an iterative unit, and holds the result.
`timescale 1ns / 1ps
`default_nettype none
module smi_back #(
	parameter int MAG_BITS = 125
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 q_valid,
	output logic                q_ready,
	input  wire smi_pkg::item_t q_item,
	output logic                out_valid,
	input  wire                 out_ready,
	output smi_pkg::res_t       out_res
);

	localparam int N  = MAG_BITS;
	localparam int CW = $clog2(MAG_BITS + 1);

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_MUL  = 7'b0000010,
		S_DIV  = 7'b0000100,
		S_GCDK = 7'b0001000,
		S_GCDX = 7'b0010000,
		S_GCDY = 7'b0100000,
		S_FIN  = 7'b1000000
	} state_t;

	state_t          state_q;
	smi_pkg::op_t    op_q;
	logic            neg_q, ovf_q;
	logic [N-1:0]    opx_q, opy_q, acc_q;
	logic [CW-1:0]   cnt_q;
	logic            out_valid_q;
	smi_pkg::res_t   out_q;

	logic            out_free, pop;
	logic [N-1:0]    a_m, b_m;
	logic            fl_ovf, fl_nan, bn, iter;
	logic [N:0]      sum, dab, dba;
	smi_pkg::res_t   quick, fin;
	logic [N+1:0]    mul_full;
	logic [N:0]      div_t, div_d;
	logic [N:0]      gcd_d;

	assign a_m      = q_item.a.mag[N-1:0];
	assign b_m      = q_item.b.mag[N-1:0];
	assign out_free = !out_valid_q || out_ready;
	assign pop      = (state_q == S_IDLE) && q_valid && out_free;
	assign q_ready  = pop;
	assign out_valid = out_valid_q;
	assign out_res   = out_q;

	// Results computed without the iterative unit, and the special cases of the iterative operations.
	always_comb begin
		fl_ovf = q_item.a.ovf || q_item.b.ovf;
		fl_nan = q_item.a.nan || q_item.b.nan;
		bn     = q_item.b.neg ^ (q_item.op == smi_pkg::OP_SUB);
		sum    = {1'b0, a_m} + {1'b0, b_m};
		dab    = {1'b0, a_m} - {1'b0, b_m};
		dba    = {1'b0, b_m} - {1'b0, a_m};
		iter   = 1'b0;
		quick  = '0;
		case (q_item.op) inside
			smi_pkg::OP_ADD, smi_pkg::OP_SUB: begin
				quick.ovf = fl_ovf;
				quick.nan = fl_nan;
				quick.neg = q_item.a.neg;
				if (fl_ovf || fl_nan) begin
					quick.mag = smi_pkg::MAG_W'(a_m);
				end else if (q_item.a.neg == bn) begin
					quick.mag = smi_pkg::MAG_W'(sum[N-1:0]);
					quick.ovf = sum[N];
				end else if (!dab[N]) begin
					quick.mag = smi_pkg::MAG_W'(dab[N-1:0]);
				end else begin
					quick.mag = smi_pkg::MAG_W'(dba[N-1:0]);
					quick.neg = !q_item.a.neg;
				end
			end
			smi_pkg::OP_MUL: begin
				quick.neg = q_item.a.neg ^ q_item.b.neg;
				if (q_item.a_zero || q_item.b_zero) begin
					quick.ovf = q_item.a.ovf;
					quick.nan = q_item.a.nan;
				end else if (fl_ovf || fl_nan) begin
					quick.ovf = fl_ovf;
					quick.nan = fl_nan;
					quick.mag = smi_pkg::MAG_W'(a_m);
				end else begin
					iter = 1'b1;
				end
			end
			smi_pkg::OP_DIV, smi_pkg::OP_MOD: begin
				if (fl_ovf) begin
					quick.ovf = 1'b1;
				end else if (fl_nan || b_m == '0) begin
					quick.nan = 1'b1;
				end else begin
					iter = 1'b1;
				end
			end
			smi_pkg::OP_AND, smi_pkg::OP_OR, smi_pkg::OP_XOR: begin
				quick.ovf = fl_ovf;
				quick.nan = fl_nan;
				quick.neg = q_item.a.neg;
				if (fl_ovf || fl_nan) begin
					quick.mag = smi_pkg::MAG_W'(a_m);
				end else if (q_item.op == smi_pkg::OP_AND) begin
					quick.mag = smi_pkg::MAG_W'(a_m & b_m);
				end else if (q_item.op == smi_pkg::OP_OR) begin
					quick.mag = smi_pkg::MAG_W'(a_m | b_m);
				end else begin
					quick.mag = smi_pkg::MAG_W'(a_m ^ b_m);
				end
			end
			smi_pkg::OP_SHL, smi_pkg::OP_SHR: begin
				quick.ovf = q_item.a.ovf;
				quick.nan = q_item.a.nan;
				if (q_item.shift <= 8'(N)) begin
					quick.neg = q_item.a.neg;
					quick.mag = (q_item.op == smi_pkg::OP_SHL) ?
						smi_pkg::MAG_W'(a_m << q_item.shift) :
						smi_pkg::MAG_W'(a_m >> q_item.shift);
				end
			end
			smi_pkg::OP_CMP: begin
				if (q_item.a.ovf || q_item.a.nan) begin
					quick.cmp = smi_pkg::CMP_LT;
				end else if (q_item.b.ovf || q_item.b.nan) begin
					quick.cmp = smi_pkg::CMP_GT;
				end else if (a_m == '0 && b_m == '0) begin
					quick.cmp = smi_pkg::CMP_EQ;
				end else if (q_item.a.neg != q_item.b.neg) begin
					quick.cmp = q_item.a.neg ? smi_pkg::CMP_LT : smi_pkg::CMP_GT;
				end else if (a_m == b_m) begin
					quick.cmp = smi_pkg::CMP_EQ;
				end else if ((a_m > b_m) ^ q_item.a.neg) begin
					quick.cmp = smi_pkg::CMP_GT;
				end else begin
					quick.cmp = smi_pkg::CMP_LT;
				end
			end
			smi_pkg::OP_GCD: begin
				if (q_item.b_zero) begin
					quick = {q_item.a.neg, q_item.a.ovf, q_item.a.nan,
						smi_pkg::MAG_W'(a_m), smi_pkg::CMP_EQ};
				end else if (q_item.a_zero || q_item.b.ovf || q_item.b.nan) begin
					quick = {q_item.b.neg, q_item.b.ovf, q_item.b.nan,
						smi_pkg::MAG_W'(b_m), smi_pkg::CMP_EQ};
				end else if (q_item.a.ovf || q_item.a.nan) begin
					quick = {q_item.a.neg, q_item.a.ovf, q_item.a.nan,
						smi_pkg::MAG_W'(a_m), smi_pkg::CMP_EQ};
				end else begin
					iter = 1'b1;
				end
			end
			default: begin
				quick = '0;
			end
		endcase
	end

	// Datapath of the iterative unit.
	always_comb begin
		mul_full = {1'b0, acc_q, 1'b0} + ((N+2)'(opy_q[N-1] ? opx_q : '0));
		div_t    = {acc_q, opx_q[N-1]};
		div_d    = div_t - {1'b0, opy_q};
		gcd_d    = {1'b0, opy_q} - {1'b0, opx_q};
		fin      = '0;
		fin.neg  = neg_q;
		case (op_q)
			smi_pkg::OP_MUL: begin
				fin.mag = smi_pkg::MAG_W'(acc_q);
				fin.ovf = ovf_q;
			end
			smi_pkg::OP_DIV: begin
				fin.mag = smi_pkg::MAG_W'(opx_q);
			end
			smi_pkg::OP_MOD: begin
				fin.mag = smi_pkg::MAG_W'(acc_q);
			end
			default: begin
				fin.neg = 1'b0;
				fin.mag = smi_pkg::MAG_W'(opx_q << cnt_q);
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (pop && iter) begin
			op_q  <= q_item.op;
			opx_q <= a_m;
			opy_q <= b_m;
			acc_q <= '0;
			ovf_q <= 1'b0;
			neg_q <= (q_item.op == smi_pkg::OP_MOD) ? q_item.a.neg :
				(q_item.a.neg ^ q_item.b.neg);
			cnt_q <= (q_item.op == smi_pkg::OP_GCD) ? '0 : CW'(N);
		end else begin
			unique case (state_q)
				S_MUL: begin
					acc_q <= mul_full[N-1:0];
					ovf_q <= ovf_q || (mul_full[N+1:N] != 2'b00);
					opy_q <= opy_q << 1;
					cnt_q <= cnt_q - 1'b1;
				end
				S_DIV: begin
					if (!div_d[N]) begin
						acc_q <= div_d[N-1:0];
					end else begin
						acc_q <= div_t[N-1:0];
					end
					opx_q <= {opx_q[N-2:0], !div_d[N]};
					cnt_q <= cnt_q - 1'b1;
				end
				S_GCDK: begin
					if (!opx_q[0] && !opy_q[0]) begin
						opx_q <= opx_q >> 1;
						opy_q <= opy_q >> 1;
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_GCDX: begin
					if (!opx_q[0]) begin
						opx_q <= opx_q >> 1;
					end
				end
				S_GCDY: begin
					if (opy_q == '0) begin
						opy_q <= opy_q;
					end else if (!opy_q[0]) begin
						opy_q <= opy_q >> 1;
					end else if (gcd_d[N]) begin
						opx_q <= opy_q;
						opy_q <= opx_q;
					end else begin
						opy_q <= gcd_d[N-1:0];
					end
				end
				default: begin
					opx_q <= opx_q;
				end
			endcase
		end
		if ((pop && !iter) || (state_q == S_FIN && out_free)) begin
			out_q <= pop ? quick : fin;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if ((pop && !iter) || (state_q == S_FIN && out_free)) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q) inside
				S_IDLE: begin
					if (pop && iter) begin
						if (q_item.op == smi_pkg::OP_MUL) begin
							state_q <= S_MUL;
						end else if (q_item.op == smi_pkg::OP_GCD) begin
							state_q <= S_GCDK;
						end else begin
							state_q <= S_DIV;
						end
					end
				end
				S_MUL, S_DIV: begin
					if (cnt_q == CW'(1)) begin
						state_q <= S_FIN;
					end
				end
				S_GCDK: begin
					if (opx_q[0] || opy_q[0]) begin
						state_q <= S_GCDX;
					end
				end
				S_GCDX: begin
					if (opx_q[0]) begin
						state_q <= S_GCDY;
					end
				end
				S_GCDY: begin
					if (opy_q == '0) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (state_q == S_IDLE))
		else $error("request taken while the unit is busy");

	a_cnt_live: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MUL || state_q == S_DIV) |-> (cnt_q != '0))
		else $error("iteration counter ran out");

	a_rem_small: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (acc_q < opy_q))
		else $error("partial remainder not below divisor");

	a_gcd_odd: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_GCDY) |-> opx_q[0])
		else $error("gcd operand lost its odd value");

	a_fin_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN && out_free) |=> out_valid_q)
		else $error("finished result not presented");

endmodule
`default_nettype wire

[design/sign_magnitude_int128_alu.sv]
// Top level of the sign-magnitude integer ALU: port packing and the two halves.
// Add, subtract, logic, shift and compare requests and every special case bypass the
// iterative unit; multiply, divide and modulo pass through the shared iterative unit at
// one bit a cycle, and gcd runs there by halvings, subtractions and swaps.
// Throughput: one request a cycle for the simple operations while m_tready is held high;
// the iterative unit takes no new request until its result is in the output register.
// Reset (arst_n, asynchronous, active low) empties the queue and the output register.
`timescale 1ns / 1ps
`default_nettype none
module sign_magnitude_int128_alu #(
	parameter int MAG_BITS = 125
) (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          s_tvalid,
	output logic         s_tready,
	// Fields from bit 0 up: action, a_negative, a_overflowed, a_not_number, a_mag_high,
	// a_mag_low, b_negative, b_overflowed, b_not_number, b_mag_high, b_mag_low,
	// shift_count, zero fill.
	input  wire  [271:0] s_tdata,
	output logic         m_tvalid,
	input  wire          m_tready,
	// Fields from bit 0 up: res_negative, res_overflowed, res_not_number, res_mag_high,
	// res_mag_low, compare_result, zero fill.
	output logic [135:0] m_tdata
);

	smi_pkg::num_t  a_raw, b_raw;
	smi_pkg::item_t q_item;
	smi_pkg::res_t  res;
	logic           q_valid, q_ready;

	// Each magnitude arrives as its upper 61 bits followed by its lower 64 bits.
	assign a_raw = {s_tdata[4], s_tdata[5], s_tdata[6], s_tdata[67:7], s_tdata[131:68]};
	assign b_raw = {s_tdata[132], s_tdata[133], s_tdata[134], s_tdata[195:135],
		s_tdata[259:196]};

	// The front end queues up to two decoded requests, so it keeps accepting while the back
	// end iterates or while a finished result waits to be taken.
	smi_front #(
		.MAG_BITS(MAG_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_tvalid),
		.in_ready    (s_tready),
		.action      (s_tdata[3:0]),
		.a_raw       (a_raw),
		.b_raw       (b_raw),
		.shift_count (s_tdata[267:260]),
		.q_valid     (q_valid),
		.q_ready     (q_ready),
		.q_item      (q_item)
	);

	// The back end finishes simple requests at once and runs multiply, divide, modulo and gcd
	// through its iterative unit before loading the output register.
	smi_back #(
		.MAG_BITS(MAG_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_ready   (q_ready),
		.q_item    (q_item),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (res)
	);

	assign m_tdata = {6'd0, res.cmp, res.mag[63:0], res.mag[124:64], res.nan, res.ovf,
		res.neg};

endmodule
`default_nettype wire
